[sv/sle_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sequential list engine: field widths,
// operation and status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_RETRIEVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOCATE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_WAIT,
    ST_SCAN,
    ST_SHIFT,
    ST_INS_WR,
    ST_DONE
  } state_t;

  // read address source
  typedef enum logic [2:0] {
    RD_POS,
    RD_ZERO,
    RD_CNT_M1,
    RD_IDX_INC,
    RD_IDX_DEC
  } rd_src_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_CNT_M1,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_RANGE,
    RES_BAD_POS,
    RES_READ,
    RES_FOUND,
    RES_INSERTED
  } res_op_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_src_t rd_src;
    idx_op_t idx_op;
    logic    wr_shift;
    logic    wr_insert;
    res_op_t res_op;
    logic    out_load;
  } sle_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              rd_ok;
    logic              ins_bad;
    logic              full;
    logic              append;
    logic              count_zero;
    logic              match;
    logic              scan_last;
    logic              shift_last;
  } sle_stat_t;

endpackage
`default_nettype wire

[sv/sle_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_req_if
// Request channel: valid/ready handshake with operation, position and value.
// ----------------------------------------------------------------------------
interface sle_req_if;
  import sle_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface
`default_nettype wire

[sv/sle_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_rsp_if
// Response channel: valid/ready handshake with status and result fields.
// ----------------------------------------------------------------------------
interface sle_rsp_if;
  import sle_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] read_value;
  logic [POS_W-1:0]          found_position;
  logic [POS_W-1:0]          list_length;

  modport source (output valid, status, read_value, found_position, list_length,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, list_length,
                  output ready);
endinterface
`default_nettype wire

[sv/sle_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/sle_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller: sequences retrieve, locate scan and insert shift, and owns the
// request/response handshakes.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire sle_pkg::sle_stat_t stat,
  output sle_pkg::sle_cmd_t       cmd
);
  import sle_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_next = ST_DONE;
        case (stat.kind)
          KIND_RETRIEVE: if (stat.rd_ok) state_next = ST_RD_WAIT;
          KIND_LOCATE:   if (!stat.count_zero) state_next = ST_SCAN;
          KIND_INSERT: begin
            if (!stat.ins_bad && !stat.full) begin
              state_next = stat.append ? ST_INS_WR : ST_SHIFT;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_RD_WAIT: state_next = ST_DONE;
      ST_SCAN: begin
        if (stat.match || stat.scan_last) state_next = ST_DONE;
      end
      ST_SHIFT: begin
        if (stat.shift_last) state_next = ST_INS_WR;
      end
      ST_INS_WR: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_src     = RD_POS;
    cmd.idx_op     = IDX_HOLD;
    cmd.res_op     = RES_NONE;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
      end
      ST_DISPATCH: begin
        case (stat.kind)
          KIND_RETRIEVE: begin
            if (stat.rd_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_POS;
            end else begin
              cmd.res_op = RES_RANGE;
            end
          end
          KIND_LOCATE: begin
            if (stat.count_zero) begin
              cmd.res_op = RES_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_ZERO;
              cmd.idx_op = IDX_ZERO;
            end
          end
          KIND_INSERT: begin
            if (stat.ins_bad) begin
              cmd.res_op = RES_BAD_POS;
            end else if (stat.full) begin
              cmd.res_op = RES_RANGE;
            end else if (!stat.append) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_CNT_M1;
              cmd.idx_op = IDX_CNT_M1;
            end
          end
          default: cmd.res_op = RES_RANGE;
        endcase
      end
      ST_RD_WAIT: begin
        cmd.res_op = RES_READ;
      end
      ST_SCAN: begin
        if (stat.match) begin
          cmd.res_op = RES_FOUND;
        end else if (stat.scan_last) begin
          cmd.res_op = RES_RANGE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_IDX_INC;
          cmd.idx_op = IDX_INC;
        end
      end
      ST_SHIFT: begin
        // move the element read last cycle up one slot, fetch the next lower
        cmd.wr_shift = 1'b1;
        if (!stat.shift_last) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_IDX_DEC;
          cmd.idx_op = IDX_DEC;
        end
      end
      ST_INS_WR: begin
        cmd.wr_insert = 1'b1;
        cmd.res_op    = RES_INSERTED;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[sv/sle_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sle_dp
// Datapath: element store, length count, scan/shift index, request capture,
// result and output registers, and the flags the controller branches on.
// ----------------------------------------------------------------------------
module sle_dp #(
  parameter int CAPACITY = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire sle_pkg::sle_cmd_t                  cmd,
  output sle_pkg::sle_stat_t                      stat,
  input  wire logic [sle_pkg::KIND_W-1:0]         in_kind,
  input  wire logic [sle_pkg::POS_W-1:0]          in_position,
  input  wire logic signed [sle_pkg::VALUE_W-1:0] in_value,
  output logic      [sle_pkg::STATUS_W-1:0]       out_status,
  output logic signed [sle_pkg::VALUE_W-1:0]      out_read_value,
  output logic      [sle_pkg::POS_W-1:0]          out_found_position,
  output logic      [sle_pkg::POS_W-1:0]          out_list_length
);
  import sle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // common compare width for position and count
  localparam int W  = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [KIND_W-1:0]   kind_q;
  logic [POS_W-1:0]    pos_q;
  logic [VALUE_W-1:0]  val_q;
  logic [CW-1:0]       count;
  logic [AW-1:0]       idx;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_rd;
  logic [POS_W-1:0]    res_found;

  logic [W-1:0]       count_w, pos_w, idx_w, pos_m1;
  logic [AW-1:0]      raddr, waddr, pos_addr, cnt_m1_addr;
  logic [VALUE_W-1:0] rdata, wdata;
  logic               we;

  assign count_w     = W'(count);
  assign pos_w       = W'(pos_q);
  assign idx_w       = W'(idx);
  assign pos_m1      = pos_w - W'(1);
  assign pos_addr    = AW'(pos_m1);
  assign cnt_m1_addr = AW'(count_w - W'(1));

  assign stat.kind       = kind_q;
  assign stat.rd_ok      = (pos_w != '0) && (pos_w <= count_w);
  assign stat.ins_bad    = (pos_w == '0) || (pos_w > count_w + W'(1));
  assign stat.full       = (count_w == W'(CAPACITY));
  assign stat.append     = (pos_w == count_w + W'(1));
  assign stat.count_zero = (count == '0);
  assign stat.match      = (rdata == val_q);
  assign stat.scan_last  = (idx_w + W'(1) == count_w);
  assign stat.shift_last = (idx_w == pos_m1);

  always_comb begin
    case (cmd.rd_src)
      RD_POS:     raddr = pos_addr;
      RD_ZERO:    raddr = '0;
      RD_CNT_M1:  raddr = cnt_m1_addr;
      RD_IDX_INC: raddr = idx + AW'(1);
      RD_IDX_DEC: raddr = idx - AW'(1);
      default:    raddr = '0;
    endcase
  end

  assign we    = cmd.wr_shift || cmd.wr_insert;
  assign waddr = cmd.wr_insert ? pos_addr : idx + AW'(1);
  assign wdata = cmd.wr_insert ? val_q : rdata;

  sle_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_insert) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= in_kind;
      pos_q  <= in_position;
      val_q  <= in_value;
    end

    case (cmd.idx_op)
      IDX_ZERO:   idx <= '0;
      IDX_CNT_M1: idx <= cnt_m1_addr;
      IDX_INC:    idx <= idx + AW'(1);
      IDX_DEC:    idx <= idx - AW'(1);
      default:    ;
    endcase

    case (cmd.res_op)
      RES_RANGE: begin
        res_status <= STATUS_RANGE;
        res_rd     <= '0;
        res_found  <= '0;
      end
      RES_BAD_POS: begin
        res_status <= STATUS_BAD_POS;
        res_rd     <= '0;
        res_found  <= '0;
      end
      RES_READ: begin
        res_status <= STATUS_OK;
        res_rd     <= rdata;
        res_found  <= '0;
      end
      RES_FOUND: begin
        res_status <= STATUS_OK;
        res_rd     <= '0;
        res_found  <= POS_W'(idx_w + W'(1));
      end
      RES_INSERTED: begin
        res_status <= STATUS_OK;
        res_rd     <= '0;
        res_found  <= '0;
      end
      default: ;
    endcase

    if (cmd.out_load) begin
      out_status         <= res_status;
      out_read_value     <= res_rd;
      out_found_position <= res_found;
      out_list_length    <= POS_W'(count_w);
    end
  end

endmodule
`default_nettype wire

[sv/sequential_list_engine_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine_unit
// Ordered list of signed 32-bit values in a RAM of CAPACITY entries.
// ----------------------------------------------------------------------------
// Each request is a retrieve (1-based position), a locate (first position
// holding a value) or an insert (shift the tail up one slot, store the value);
// every request yields one response carrying status, read value, found
// position and the list length after the operation. Requests are handled one
// at a time and the element RAM does one read and one write per cycle; a locate
// compares one element per cycle until a hit or the list end, and an insert
// moves one element of the tail per cycle, then writes the new value. A finished
// response sits in an output register, so the next request is taken while it
// waits. The list is empty after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sequential_list_engine_unit #(
  parameter int CAPACITY = 128
) (
  input wire logic  clk,
  input wire logic  rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);
  import sle_pkg::*;

  sle_cmd_t  cmd;
  sle_stat_t stat;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sle_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (req.kind),
    .in_position       (req.position),
    .in_value          (req.value),
    .out_status        (rsp.status),
    .out_read_value    (rsp.read_value),
    .out_found_position(rsp.found_position),
    .out_list_length   (rsp.list_length)
  );

endmodule
`default_nettype wire

[sim/tb_sequential_list_engine_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sequential_list_engine_unit
// Self-checking bench for the sequential list engine. A shadow copy of the
// list predicts every response; requests cover edge cases first, then random
// retrieve/locate/insert mixes while the list grows, fills and stays full,
// with random gaps on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine_unit;
  import sle_pkg::*;

  localparam int CAPACITY      = 128;
  localparam int HOLD_CYCLES   = 400;
  localparam int WATCHDOG_MAX  = 6000;
  localparam int SETTLE_CYCLES = 150;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]          found_position;
    logic [POS_W-1:0]          list_length;
  } list_result_t;

  logic clk;
  logic rst;

  sle_req_if req_ch ();
  sle_rsp_if rsp_ch ();

  sequential_list_engine_unit #(.CAPACITY(CAPACITY)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow of the list contents and length
  logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
  int                        shadow_len;
  list_result_t              pending_results[$];

  int error_count;
  int rsp_count;
  int idle_cycles;
  bit idle_on;
  bit hold_request;

  initial begin
    clk = 1'b0;
  end
  always #4 clk = ~clk;

  function automatic list_result_t predict_list_op(input logic [KIND_W-1:0] kind,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [VALUE_W-1:0] val);
    list_result_t r;
    int p;
    r.status         = STATUS_RANGE;
    r.read_value     = '0;
    r.found_position = '0;
    p = int'(pos);
    case (kind)
      KIND_RETRIEVE: begin
        if (p >= 1 && p <= shadow_len) begin
          r.read_value = shadow_list[p-1];
          r.status     = STATUS_OK;
        end
      end
      KIND_LOCATE: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == val) begin
            r.found_position = POS_W'(i + 1);
            r.status         = STATUS_OK;
            break;
          end
        end
      end
      KIND_INSERT: begin
        // position check comes before the full check
        if (p < 1 || p > shadow_len + 1) begin
          r.status = STATUS_BAD_POS;
        end else if (shadow_len < CAPACITY) begin
          for (int i = shadow_len; i > p - 1; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = val;
          shadow_len++;
          r.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    r.list_length = POS_W'(shadow_len);
    return r;
  endfunction

  // corner-heavy value mix so duplicates and extremes show up
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(9, 0);
    case (sel)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3, 4:    return $urandom_range(7, 0);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                         input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = idle_on ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= kind;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_list_op(kind, pos, val));
  endtask

  task automatic send_random_op();
    int r;
    logic [POS_W-1:0] pos;
    logic signed [VALUE_W-1:0] val;
    r   = $urandom_range(99, 0);
    pos = POS_W'($urandom_range(255, 0));
    val = pick_value();
    if (r < 22) begin
      if ($urandom_range(99, 0) < 85) pos = POS_W'($urandom_range(shadow_len + 1, 1));
      send_op(KIND_INSERT, pos, val);
    end else if (r < 57) begin
      if (shadow_len > 0 && $urandom_range(1, 0))
        val = shadow_list[$urandom_range(shadow_len - 1, 0)];
      send_op(KIND_LOCATE, pos, val);
    end else if (r < 97) begin
      if (shadow_len > 0 && $urandom_range(99, 0) < 85)
        pos = POS_W'($urandom_range(shadow_len, 1));
      send_op(KIND_RETRIEVE, pos, val);
    end else begin
      send_op(KIND_UNUSED, pos, val);
    end
  endtask

  task automatic drain_pending();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // empty-list corners, then a small list with extremes and duplicates
  task automatic test_directed_edges();
    idle_on = 1'b1;
    send_op(KIND_RETRIEVE, 8'd0, 32'sd0);
    send_op(KIND_RETRIEVE, 8'd1, 32'sd0);
    send_op(KIND_LOCATE, 8'd0, 32'sd0);
    send_op(KIND_INSERT, 8'd0, 32'sd5);
    send_op(KIND_INSERT, 8'd2, 32'sd5);
    send_op(KIND_INSERT, 8'd255, 32'sd5);
    send_op(KIND_UNUSED, 8'd255, -32'sd1);
    send_op(KIND_INSERT, 8'd1, 32'sh8000_0000);
    send_op(KIND_INSERT, 8'd1, 32'sh7fff_ffff);
    send_op(KIND_INSERT, 8'd3, 32'sd0);
    send_op(KIND_INSERT, 8'd2, -32'sd1);
    send_op(KIND_INSERT, 8'd4, 32'sh7fff_ffff);
    for (int p = 1; p <= 5; p++) send_op(KIND_RETRIEVE, POS_W'(p), 32'sd0);
    send_op(KIND_RETRIEVE, 8'd6, 32'sd0);
    send_op(KIND_RETRIEVE, 8'd255, 32'sd0);
    send_op(KIND_LOCATE, 8'd255, 32'sh7fff_ffff);
    send_op(KIND_LOCATE, 8'd0, 32'sd0);
    send_op(KIND_LOCATE, 8'd0, 32'sd12345);
    send_op(KIND_INSERT, 8'd7, 32'sd1);
    send_op(KIND_INSERT, 8'd6, 32'sh5555_aaaa);
    drain_pending();
  endtask

  task automatic test_random_mixed();
    for (int n = 0; n < 550; n++) begin
      idle_on = ((n / 50) % 2) == 0;
      send_random_op();
    end
    drain_pending();
  endtask

  task automatic test_fill_to_capacity();
    idle_on = 1'b1;
    while (shadow_len < CAPACITY)
      send_op(KIND_INSERT, POS_W'($urandom_range(shadow_len + 1, 1)), pick_value());
    send_op(KIND_INSERT, 8'd129, 32'sd9);
    send_op(KIND_INSERT, 8'd1, 32'sd9);
    send_op(KIND_INSERT, 8'd64, 32'sd9);
    send_op(KIND_INSERT, 8'd130, 32'sd9);
    send_op(KIND_INSERT, 8'd255, 32'sd9);
    send_op(KIND_INSERT, 8'd0, 32'sd9);
    send_op(KIND_RETRIEVE, 8'd128, 32'sd0);
    send_op(KIND_RETRIEVE, 8'd129, 32'sd0);
    send_op(KIND_LOCATE, 8'd0, shadow_list[CAPACITY-1]);
    send_op(KIND_LOCATE, 8'd0, $urandom);
    drain_pending();
  endtask

  // response side stalls long while requests keep coming back to back
  task automatic test_output_backpressure();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    for (int n = 0; n < 12; n++) send_random_op();
    drain_pending();
  endtask

  task automatic test_random_full_list();
    for (int n = 0; n < 350; n++) begin
      idle_on = ((n / 70) % 2) == 0;
      send_random_op();
    end
    drain_pending();
  endtask

  // response ready: random stall per transfer, plus the long hold on request
  initial begin : rsp_sink
    int stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = idle_on ? $urandom_range(13, 0) : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("response %0d with nothing outstanding: status %0d length %0d",
                   rsp_count, rsp_ch.status, rsp_ch.list_length);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.read_value ||
            rsp_ch.found_position !== want.found_position ||
            rsp_ch.list_length !== want.list_length) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch on response %0d: status %0d/%0d read_value %0d/%0d ",
                      "found %0d/%0d length %0d/%0d (expected/actual)"}, rsp_count,
                     want.status, rsp_ch.status, want.read_value, rsp_ch.read_value,
                     want.found_position, rsp_ch.found_position,
                     want.list_length, rsp_ch.list_length);
        end
      end
    end
  end

  // watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    error_count     = 0;
    rsp_count       = 0;
    shadow_len      = 0;
    idle_on         = 1'b1;
    hold_request    = 1'b0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.kind     <= KIND_RETRIEVE;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_random_mixed();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_full_list();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
